// File: hdl/mtrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrs_pkg
// Shared types and constants for the transform decomposition pipeline.
// ----------------------------------------------------------------------------
package mtrs_pkg;

    // one square-root digit per stage, one quotient bit per stage
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 62;

    localparam int QBITS = 30;
    localparam logic signed [33:0] QONE = 34'sd1073741824;
    localparam logic [30:0] SCALE_MAX = 31'h7FFFFFFF;

    typedef enum logic [1:0] {
        BR_TRACE,
        BR_X,
        BR_Y,
        BR_Z
    } branch_t;

    // what the branch stage hands on to the root and quotient units
    typedef struct packed {
        branch_t          branch;
        logic [63:0]      rad;
        logic [2:0][31:0] dmag;
        logic [2:0]       dsign;
    } quat_seed_t;

endpackage

// File: hdl/matrix_to_trs_decompose_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_to_trs_decompose_top
// Splits an affine transform into position, per-axis scale and a unit
// rotation quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the nine basis elements and the translation and raise start for
//   one cycle per beat. busy is always low, so a beat is taken on every
//   cycle that start is high, back to back without gaps.
//   Each result is shown on pos_*, scale_* and quat_* for one cycle with
//   done high. Results come out in the order the beats went in, one per
//   cycle at most.
//   Throughput is one beat per cycle. The latency is set by the chain of
//   three square-root units (32 stages each) and three divider units
//   (62 stages each), one digit or quotient bit per stage.
//   The receiver cannot hold results off; done is a one-cycle strobe.
//   Reset clears the valid pipe only, so nothing is shown after reset until
//   new beats arrive; data in flight at reset is dropped.
// ----------------------------------------------------------------------------
module matrix_to_trs_decompose_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] row0_x,
    input  logic signed [31:0] row0_y,
    input  logic signed [31:0] row0_z,
    input  logic signed [31:0] row1_x,
    input  logic signed [31:0] row1_y,
    input  logic signed [31:0] row1_z,
    input  logic signed [31:0] row2_x,
    input  logic signed [31:0] row2_y,
    input  logic signed [31:0] row2_z,
    input  logic signed [31:0] trans_x,
    input  logic signed [31:0] trans_y,
    input  logic signed [31:0] trans_z,
    output logic               done,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic        [30:0] scale_x,
    output logic        [30:0] scale_y,
    output logic        [30:0] scale_z,
    output logic signed [31:0] quat_w,
    output logic signed [31:0] quat_x,
    output logic signed [31:0] quat_y,
    output logic signed [31:0] quat_z
);

    localparam int S_SUM  = 2;
    localparam int S_LEN  = S_SUM + mtrs_pkg::SQRT_STEPS;
    localparam int S_RQ   = S_LEN + mtrs_pkg::DIV_STEPS;
    localparam int S_R    = S_RQ + 1;
    localparam int S_B2   = S_R + 2;
    localparam int S_ROOT = S_B2 + mtrs_pkg::SQRT_STEPS;
    localparam int S_QQ   = S_ROOT + mtrs_pkg::DIV_STEPS;
    localparam int S_Q    = S_QQ + 1;
    localparam int S_N1   = S_Q + 1;
    localparam int S_N2   = S_N1 + 1;
    localparam int S_N3   = S_N2 + 1;
    localparam int S_N4   = S_N3 + 1;
    localparam int S_NRM  = S_N4 + mtrs_pkg::SQRT_STEPS;
    localparam int S_QD   = S_NRM + mtrs_pkg::DIV_STEPS;
    localparam int S_OUT  = S_QD + 1;

    logic [S_OUT:1] valid_reg;

    logic [8:0][31:0] e_in;
    logic [8:0][31:0] e_mag;

    // payload delay lines, indexed by pipeline stage
    logic [2:0][31:0] trans_dly_reg [1:S_OUT];
    logic [8:0][31:0] emag_dly_reg  [1:S_LEN];
    logic [8:0]       esign_dly_reg [1:S_RQ];
    logic [2:0]       lz_dly_reg    [S_LEN+1:S_RQ];
    logic [2:0][30:0] scale_dly_reg [S_LEN+1:S_OUT];
    logic [2:0][31:0] dmag_dly_reg  [S_B2+1:S_ROOT];
    logic [2:0]       dsign_dly_reg [S_B2+1:S_QQ];
    mtrs_pkg::branch_t br_dly_reg   [S_B2+1:S_QQ];
    logic [30:0]      diag_dly_reg  [S_ROOT+1:S_QQ];
    logic             sz_dly_reg    [S_ROOT+1:S_QQ];
    logic [3:0]       qneg_dly_reg  [S_Q:S_QD];
    logic [3:0][30:0] ms_dly_reg    [S_N2:S_NRM];
    logic             nz_dly_reg    [S_NRM+1:S_QD];

    logic [8:0][63:0] prod_reg;
    logic [2:0][63:0] sum_reg;
    logic [2:0][31:0] len;
    logic [8:0][61:0] rq;
    logic [8:0][31:0] r_reg;
    logic [8:0][31:0] r_next;
    mtrs_pkg::quat_seed_t seed;
    logic [31:0]      root_r;
    logic [2:0][61:0] qq;
    logic [3:0][61:0] m_reg;
    logic [3:0][61:0] m_next;
    logic [3:0]       qneg_next;
    logic [3:0][61:0] m1_reg;
    logic [5:0]       shamt_reg;
    logic [5:0]       shamt_next;
    logic [3:0][61:0] sq_reg;
    logic [63:0]      nsum_reg;
    logic [31:0]      norm;
    logic [3:0][61:0] qd;
    logic [3:0][31:0] quat_reg;
    logic [3:0][31:0] quat_next;
    logic [2:0][30:0] scale_next;

    assign busy = 1'b0;

    assign e_in[0] = row0_x;
    assign e_in[1] = row0_y;
    assign e_in[2] = row0_z;
    assign e_in[3] = row1_x;
    assign e_in[4] = row1_y;
    assign e_in[5] = row1_z;
    assign e_in[6] = row2_x;
    assign e_in[7] = row2_y;
    assign e_in[8] = row2_z;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            e_mag[k] = e_in[k][31] ? 32'(32'd0 - e_in[k]) : e_in[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[S_OUT-1:1], start && !busy};
    end

    // ---- row lengths ----
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            prod_reg[k] <= {32'd0, e_mag[k]} * {32'd0, e_mag[k]};
        end
        for (int i = 0; i < 3; i++)
        begin
            sum_reg[i] <= prod_reg[3*i] + prod_reg[3*i+1] + prod_reg[3*i+2];
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_len
        mtrs_isqrt u_len_sqrt (
            .clk      (clk),
            .radicand (sum_reg[i]),
            .root     (len[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            scale_next[i] = len[i][31] ? mtrs_pkg::SCALE_MAX : len[i][30:0];
        end
    end

    // ---- rotation matrix ----
    for (genvar k = 0; k < 9; k++)
    begin : g_rot
        mtrs_qdiv u_rot_div (
            .clk      (clk),
            .dividend ({emag_dly_reg[S_LEN][k], 30'b0}),
            .divisor  ({1'b0, len[k/3]}),
            .quotient (rq[k])
        );
    end

    always_comb
    begin
        logic [31:0] qv;
        for (int k = 0; k < 9; k++)
        begin
            qv = {1'b0, rq[k][30:0]};
            if (lz_dly_reg[S_RQ][k/3])
                r_next[k] = '0;
            else if (esign_dly_reg[S_RQ][k])
                r_next[k] = 32'(32'd0 - qv);
            else
                r_next[k] = qv;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    mtrs_branch u_branch (
        .clk  (clk),
        .rot  (r_reg),
        .seed (seed)
    );

    // ---- branch root and off-diagonal quotients ----
    mtrs_isqrt u_branch_sqrt (
        .clk      (clk),
        .radicand (seed.rad),
        .root     (root_r)
    );

    for (genvar j = 0; j < 3; j++)
    begin : g_quot
        mtrs_qdiv u_quot_div (
            .clk      (clk),
            .dividend ({dmag_dly_reg[S_ROOT][j], 30'b0}),
            .divisor  ({root_r, 1'b0}),
            .quotient (qq[j])
        );
    end

    always_comb
    begin
        logic [61:0] qm [0:2];
        logic [2:0]  qs;
        logic [61:0] dg;
        for (int j = 0; j < 3; j++)
        begin
            qm[j] = sz_dly_reg[S_QQ] ? '0 : qq[j];
            qs[j] = dsign_dly_reg[S_QQ][j] && !sz_dly_reg[S_QQ];
        end
        dg = {31'd0, diag_dly_reg[S_QQ]};
        // the diagonal term takes the slot of its branch, quotients fill the rest
        case (br_dly_reg[S_QQ])
            mtrs_pkg::BR_TRACE:
            begin
                m_next    = {qm[2], qm[1], qm[0], dg};
                qneg_next = {qs, 1'b0};
            end
            mtrs_pkg::BR_X:
            begin
                m_next    = {qm[2], qm[1], dg, qm[0]};
                qneg_next = {qs[2], qs[1], 1'b0, qs[0]};
            end
            mtrs_pkg::BR_Y:
            begin
                m_next    = {qm[2], dg, qm[1], qm[0]};
                qneg_next = {qs[2], 1'b0, qs[1], qs[0]};
            end
            default:
            begin
                m_next    = {dg, qm[2], qm[1], qm[0]};
                qneg_next = {1'b0, qs};
            end
        endcase
    end

    // ---- renormalisation ----
    always_comb
    begin
        logic [61:0] all_bits;
        all_bits   = m_reg[0] | m_reg[1] | m_reg[2] | m_reg[3];
        shamt_next = '0;
        for (int i = 31; i < 62; i++)
        begin
            if (all_bits[i])
                shamt_next = 6'(i - 30);
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        m1_reg    <= m_reg;
        shamt_reg <= shamt_next;
        for (int j = 0; j < 4; j++)
        begin
            sq_reg[j] <= {31'd0, ms_dly_reg[S_N2][j]} * {31'd0, ms_dly_reg[S_N2][j]};
        end
        nsum_reg <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]}
                  + {2'b00, sq_reg[2]} + {2'b00, sq_reg[3]};
    end

    mtrs_isqrt u_norm_sqrt (
        .clk      (clk),
        .radicand (nsum_reg),
        .root     (norm)
    );

    for (genvar j = 0; j < 4; j++)
    begin : g_norm
        mtrs_qdiv u_norm_div (
            .clk      (clk),
            .dividend ({1'b0, ms_dly_reg[S_NRM][j], 30'b0}),
            .divisor  ({1'b0, norm}),
            .quotient (qd[j])
        );
    end

    always_comb
    begin
        logic [31:0] v;
        for (int j = 0; j < 4; j++)
        begin
            v = {1'b0, qd[j][30:0]};
            if (nz_dly_reg[S_QD])
                quat_next[j] = (j == 0) ? 32'(mtrs_pkg::QONE) : '0;
            else if (qneg_dly_reg[S_QD][j])
                quat_next[j] = 32'(32'd0 - v);
            else
                quat_next[j] = v;
        end
    end

    always_ff @(posedge clk)
    begin
        quat_reg <= quat_next;
    end

    // ---- payload delay lines ----
    always_ff @(posedge clk)
    begin
        trans_dly_reg[1] <= {trans_z, trans_y, trans_x};
        for (int i = 2; i <= S_OUT; i++)
            trans_dly_reg[i] <= trans_dly_reg[i-1];

        emag_dly_reg[1] <= e_mag;
        for (int i = 2; i <= S_LEN; i++)
            emag_dly_reg[i] <= emag_dly_reg[i-1];

        for (int k = 0; k < 9; k++)
            esign_dly_reg[1][k] <= e_in[k][31];
        for (int i = 2; i <= S_RQ; i++)
            esign_dly_reg[i] <= esign_dly_reg[i-1];

        for (int k = 0; k < 3; k++)
            lz_dly_reg[S_LEN+1][k] <= (len[k] == '0);
        for (int i = S_LEN + 2; i <= S_RQ; i++)
            lz_dly_reg[i] <= lz_dly_reg[i-1];

        scale_dly_reg[S_LEN+1] <= scale_next;
        for (int i = S_LEN + 2; i <= S_OUT; i++)
            scale_dly_reg[i] <= scale_dly_reg[i-1];

        dmag_dly_reg[S_B2+1]  <= seed.dmag;
        dsign_dly_reg[S_B2+1] <= seed.dsign;
        br_dly_reg[S_B2+1]    <= seed.branch;
        for (int i = S_B2 + 2; i <= S_ROOT; i++)
            dmag_dly_reg[i] <= dmag_dly_reg[i-1];
        for (int i = S_B2 + 2; i <= S_QQ; i++)
        begin
            dsign_dly_reg[i] <= dsign_dly_reg[i-1];
            br_dly_reg[i]    <= br_dly_reg[i-1];
        end

        diag_dly_reg[S_ROOT+1] <= root_r[31:1];
        sz_dly_reg[S_ROOT+1]   <= (root_r == '0);
        for (int i = S_ROOT + 2; i <= S_QQ; i++)
        begin
            diag_dly_reg[i] <= diag_dly_reg[i-1];
            sz_dly_reg[i]   <= sz_dly_reg[i-1];
        end

        qneg_dly_reg[S_Q] <= qneg_next;
        for (int i = S_Q + 1; i <= S_QD; i++)
            qneg_dly_reg[i] <= qneg_dly_reg[i-1];

        for (int j = 0; j < 4; j++)
            ms_dly_reg[S_N2][j] <= 31'(m1_reg[j] >> shamt_reg);
        for (int i = S_N2 + 1; i <= S_NRM; i++)
            ms_dly_reg[i] <= ms_dly_reg[i-1];

        nz_dly_reg[S_NRM+1] <= (norm == '0);
        for (int i = S_NRM + 2; i <= S_QD; i++)
            nz_dly_reg[i] <= nz_dly_reg[i-1];
    end

    assign done    = valid_reg[S_OUT];
    assign pos_x   = trans_dly_reg[S_OUT][0];
    assign pos_y   = trans_dly_reg[S_OUT][1];
    assign pos_z   = trans_dly_reg[S_OUT][2];
    assign scale_x = scale_dly_reg[S_OUT][0];
    assign scale_y = scale_dly_reg[S_OUT][1];
    assign scale_z = scale_dly_reg[S_OUT][2];
    assign quat_w  = quat_reg[0];
    assign quat_x  = quat_reg[1];
    assign quat_y  = quat_reg[2];
    assign quat_z  = quat_reg[3];

endmodule

// File: hdl/mtrs_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrs_isqrt
// Pipelined integer square root, floor(sqrt(radicand)), 64-bit in, 32-bit out,
// one root digit per stage.
// ----------------------------------------------------------------------------
module mtrs_isqrt (
    input  logic        clk,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    logic [63:0] x_reg    [0:mtrs_pkg::SQRT_STEPS-1];
    logic [33:0] rem_reg  [0:mtrs_pkg::SQRT_STEPS-1];
    logic [31:0] root_reg [0:mtrs_pkg::SQRT_STEPS-1];
    logic [63:0] x_next    [0:mtrs_pkg::SQRT_STEPS-1];
    logic [33:0] rem_next  [0:mtrs_pkg::SQRT_STEPS-1];
    logic [31:0] root_next [0:mtrs_pkg::SQRT_STEPS-1];

    always_comb
    begin
        logic [63:0] x_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [35:0] t;
        logic [35:0] trial;
        for (int i = 0; i < mtrs_pkg::SQRT_STEPS; i++)
        begin
            if (i == 0)
            begin
                x_in    = radicand;
                rem_in  = '0;
                root_in = '0;
            end
            else
            begin
                x_in    = x_reg[i-1];
                rem_in  = rem_reg[i-1];
                root_in = root_reg[i-1];
            end
            t     = {rem_in, x_in[63:62]};
            trial = {2'b00, root_in, 2'b01};
            if (t >= trial)
            begin
                rem_next[i]  = 34'(t - trial);
                root_next[i] = {root_in[30:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = t[33:0];
                root_next[i] = {root_in[30:0], 1'b0};
            end
            x_next[i] = {x_in[61:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mtrs_pkg::SQRT_STEPS; i++)
        begin
            x_reg[i]    <= x_next[i];
            rem_reg[i]  <= rem_next[i];
            root_reg[i] <= root_next[i];
        end
    end

    assign root = root_reg[mtrs_pkg::SQRT_STEPS-1];

endmodule

// File: hdl/mtrs_qdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrs_qdiv
// Pipelined restoring divider, 62-bit dividend by 33-bit divisor, one
// quotient bit per stage. A zero divisor gives a meaningless quotient.
// ----------------------------------------------------------------------------
module mtrs_qdiv (
    input  logic        clk,
    input  logic [61:0] dividend,
    input  logic [32:0] divisor,
    output logic [61:0] quotient
);

    // dividend bits shift out at the top while quotient bits shift in below
    logic [61:0] dq_reg   [0:mtrs_pkg::DIV_STEPS-1];
    logic [32:0] rem_reg  [0:mtrs_pkg::DIV_STEPS-1];
    logic [32:0] dvs_reg  [0:mtrs_pkg::DIV_STEPS-1];
    logic [61:0] dq_next  [0:mtrs_pkg::DIV_STEPS-1];
    logic [32:0] rem_next [0:mtrs_pkg::DIV_STEPS-1];
    logic [32:0] dvs_next [0:mtrs_pkg::DIV_STEPS-1];

    always_comb
    begin
        logic [61:0] dq_in;
        logic [32:0] rem_in;
        logic [32:0] dvs_in;
        logic [33:0] t;
        logic        qbit;
        for (int i = 0; i < mtrs_pkg::DIV_STEPS; i++)
        begin
            if (i == 0)
            begin
                dq_in  = dividend;
                rem_in = '0;
                dvs_in = divisor;
            end
            else
            begin
                dq_in  = dq_reg[i-1];
                rem_in = rem_reg[i-1];
                dvs_in = dvs_reg[i-1];
            end
            t = {rem_in, dq_in[61]};
            if (t >= {1'b0, dvs_in})
            begin
                rem_next[i] = 33'(t - {1'b0, dvs_in});
                qbit        = 1'b1;
            end
            else
            begin
                rem_next[i] = t[32:0];
                qbit        = 1'b0;
            end
            dq_next[i]  = {dq_in[60:0], qbit};
            dvs_next[i] = dvs_in;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mtrs_pkg::DIV_STEPS; i++)
        begin
            dq_reg[i]  <= dq_next[i];
            rem_reg[i] <= rem_next[i];
            dvs_reg[i] <= dvs_next[i];
        end
    end

    assign quotient = dq_reg[mtrs_pkg::DIV_STEPS-1];

endmodule

// File: hdl/mtrs_branch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrs_branch
// Two-stage trace and branch selection: picks the quaternion branch, forms
// the clamped radicand and the three off-diagonal terms for the quotients.
// ----------------------------------------------------------------------------
module mtrs_branch (
    input  logic                   clk,
    input  logic [8:0][31:0]       rot,
    output mtrs_pkg::quat_seed_t   seed
);

    logic signed [31:0] r [0:8];

    // first stage
    logic signed [33:0] tr_reg, radt_reg, radx_reg, rady_reg, radz_reg;
    logic               c0_reg, c1_reg;
    logic signed [32:0] da_reg, db_reg, dc_reg, dd_reg, de_reg, df_reg;

    mtrs_pkg::quat_seed_t seed_reg, seed_next;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            r[k] = $signed(rot[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        tr_reg   <= 34'(r[0]) + 34'(r[4]) + 34'(r[8]);
        radt_reg <= mtrs_pkg::QONE + 34'(r[0]) + 34'(r[4]) + 34'(r[8]);
        radx_reg <= mtrs_pkg::QONE + 34'(r[0]) - 34'(r[4]) - 34'(r[8]);
        rady_reg <= mtrs_pkg::QONE + 34'(r[4]) - 34'(r[0]) - 34'(r[8]);
        radz_reg <= mtrs_pkg::QONE + 34'(r[8]) - 34'(r[0]) - 34'(r[4]);
        c0_reg   <= (r[0] > r[4]) && (r[0] > r[8]);
        c1_reg   <= r[4] > r[8];
        da_reg   <= 33'(r[5]) - 33'(r[7]);
        db_reg   <= 33'(r[6]) - 33'(r[2]);
        dc_reg   <= 33'(r[1]) - 33'(r[3]);
        dd_reg   <= 33'(r[3]) + 33'(r[1]);
        de_reg   <= 33'(r[6]) + 33'(r[2]);
        df_reg   <= 33'(r[7]) + 33'(r[5]);
    end

    always_comb
    begin
        logic signed [33:0] rad;
        logic signed [32:0] d [0:2];
        if (tr_reg > 0)
        begin
            seed_next.branch = mtrs_pkg::BR_TRACE;
            rad  = radt_reg;
            d[0] = da_reg;
            d[1] = db_reg;
            d[2] = dc_reg;
        end
        else if (c0_reg)
        begin
            seed_next.branch = mtrs_pkg::BR_X;
            rad  = radx_reg;
            d[0] = da_reg;
            d[1] = dd_reg;
            d[2] = de_reg;
        end
        else if (c1_reg)
        begin
            seed_next.branch = mtrs_pkg::BR_Y;
            rad  = rady_reg;
            d[0] = db_reg;
            d[1] = dd_reg;
            d[2] = df_reg;
        end
        else
        begin
            seed_next.branch = mtrs_pkg::BR_Z;
            rad  = radz_reg;
            d[0] = dc_reg;
            d[1] = de_reg;
            d[2] = df_reg;
        end
        // negative or zero radicand clamps to zero
        if (rad <= 0)
            seed_next.rad = '0;
        else
            seed_next.rad = {1'b0, rad[32:0], 30'b0};
        for (int j = 0; j < 3; j++)
        begin
            seed_next.dsign[j] = d[j][32];
            seed_next.dmag[j]  = d[j][32] ? 32'(-d[j]) : d[j][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg <= seed_next;
    end

    assign seed = seed_reg;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the transform decomposition pipeline: directed corner transforms,
// then random rotations, scaled and skewed bases and raw bit patterns, each
// result compared field by field against an in-bench integer predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY = 293;
    localparam int N_RANDOM = 1200;
    localparam longint Q30 = 64'sd1 << 30;

    typedef struct packed {
        logic signed [31:0] px, py, pz;
        logic [30:0]        sx, sy, sz;
        logic signed [31:0] qw, qx, qy, qz;
    } trs_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] elem [0:8];
    logic signed [31:0] tx, ty, tz;
    logic done;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [30:0] scale_x, scale_y, scale_z;
    logic signed [31:0] quat_w, quat_x, quat_y, quat_z;

    matrix_to_trs_decompose_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .row0_x  (elem[0]),
        .row0_y  (elem[1]),
        .row0_z  (elem[2]),
        .row1_x  (elem[3]),
        .row1_y  (elem[4]),
        .row1_z  (elem[5]),
        .row2_x  (elem[6]),
        .row2_y  (elem[7]),
        .row2_z  (elem[8]),
        .trans_x (tx),
        .trans_y (ty),
        .trans_z (tz),
        .done    (done),
        .pos_x   (pos_x),
        .pos_y   (pos_y),
        .pos_z   (pos_z),
        .scale_x (scale_x),
        .scale_y (scale_y),
        .scale_z (scale_z),
        .quat_w  (quat_w),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z)
    );

    // bit-serial integer square root, floor
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] mag(input longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    // trunc(a * 2^30 / d), zero when d is zero
    function automatic longint frac_div(input longint a, input logic [63:0] d);
        logic [63:0] q;
        if (d == 0)
            return 0;
        q = (mag(a) << 30) / d;
        return a < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [63:0] branch_sqrt(input longint rad);
        if (rad <= 0)
            return 0;
        return int_sqrt(64'(rad) << 30);
    endfunction

    function automatic trs_t decompose(input logic signed [31:0] m [0:8],
                                       input logic signed [31:0] t0,
                                       input logic signed [31:0] t1,
                                       input logic signed [31:0] t2);
        trs_t o;
        longint r [0:2][0:2];
        longint q [0:3];
        logic [63:0] mg [0:3];
        logic [63:0] acc, len, root, s, n, v;
        logic [30:0] sc [0:2];
        longint tr;
        bit big;
        o.px = t0;
        o.py = t1;
        o.pz = t2;
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += mag(m[i*3+j]) * mag(m[i*3+j]);
            len = int_sqrt(acc);
            sc[i] = len > 64'h7FFFFFFF ? 31'h7FFFFFFF : len[30:0];
            for (int j = 0; j < 3; j++)
                r[i][j] = len != 0 ? frac_div(m[i*3+j], len) : 0;
        end
        o.sx = sc[0];
        o.sy = sc[1];
        o.sz = sc[2];
        tr = r[0][0] + r[1][1] + r[2][2];
        if (tr > 0)
        begin
            root = branch_sqrt(tr + Q30);
            s = 2 * root;
            q[0] = longint'(root >> 1);
            q[1] = frac_div(r[1][2] - r[2][1], s);
            q[2] = frac_div(r[2][0] - r[0][2], s);
            q[3] = frac_div(r[0][1] - r[1][0], s);
        end
        else if (r[0][0] > r[1][1] && r[0][0] > r[2][2])
        begin
            root = branch_sqrt(Q30 + r[0][0] - r[1][1] - r[2][2]);
            s = 2 * root;
            q[0] = frac_div(r[1][2] - r[2][1], s);
            q[1] = longint'(root >> 1);
            q[2] = frac_div(r[1][0] + r[0][1], s);
            q[3] = frac_div(r[2][0] + r[0][2], s);
        end
        else if (r[1][1] > r[2][2])
        begin
            root = branch_sqrt(Q30 + r[1][1] - r[0][0] - r[2][2]);
            s = 2 * root;
            q[0] = frac_div(r[2][0] - r[0][2], s);
            q[1] = frac_div(r[1][0] + r[0][1], s);
            q[2] = longint'(root >> 1);
            q[3] = frac_div(r[2][1] + r[1][2], s);
        end
        else
        begin
            root = branch_sqrt(Q30 + r[2][2] - r[0][0] - r[1][1]);
            s = 2 * root;
            q[0] = frac_div(r[0][1] - r[1][0], s);
            q[1] = frac_div(r[2][0] + r[0][2], s);
            q[2] = frac_div(r[2][1] + r[1][2], s);
            q[3] = longint'(root >> 1);
        end
        for (int i = 0; i < 4; i++)
            mg[i] = mag(q[i]);
        // halve together until every magnitude fits below 2^31
        do
        begin
            big = 0;
            for (int i = 0; i < 4; i++)
                if (mg[i] >= (64'd1 << 31))
                    big = 1;
            if (big)
                for (int i = 0; i < 4; i++)
                    mg[i] = mg[i] >> 1;
        end
        while (big);
        acc = 0;
        for (int i = 0; i < 4; i++)
            acc += mg[i] * mg[i];
        n = int_sqrt(acc);
        for (int i = 0; i < 4; i++)
        begin
            if (n == 0)
                q[i] = i == 0 ? Q30 : 0;
            else
            begin
                v = (mg[i] << 30) / n;
                q[i] = q[i] < 0 ? -longint'(v) : longint'(v);
            end
        end
        o.qw = q[0][31:0];
        o.qx = q[1][31:0];
        o.qy = q[2][31:0];
        o.qz = q[3][31:0];
        return o;
    endfunction

    class trs_scoreboard;
        trs_t pending [$];
        int   mismatches;
        int   checked;

        function void note_beat(trs_t e);
            pending.insert(pending.size(), e);
        endfunction

        function void check_result(trs_t got);
            trs_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch at result %0d", checked);
                    $display("  pos   exp %h %h %h got %h %h %h",
                             e.px, e.py, e.pz, got.px, got.py, got.pz);
                    $display("  scale exp %h %h %h got %h %h %h",
                             e.sx, e.sy, e.sz, got.sx, got.sy, got.sz);
                    $display("  quat  exp %h %h %h %h got %h %h %h %h",
                             e.qw, e.qx, e.qy, e.qz, got.qw, got.qx, got.qy, got.qz);
                end
            end
        endfunction
    endclass

    trs_scoreboard sb;
    int n_beats;
    bit gaps_on;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
                             quat_w, quat_x, quat_y, quat_z});
    end

    // note the beat at the accepting edge so the check sees it in order
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            sb.note_beat(decompose(elem, tx, ty, tz));
            n_beats++;
        end
    end

    task automatic send(input logic signed [31:0] m [0:9-1],
                        input logic signed [31:0] a, b, c);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            start <= 0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        for (int i = 0; i < 9; i++)
            elem[i] <= m[i];
        tx <= a;
        ty <= b;
        tz <= c;
        start <= 1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 0;
        @(negedge clk);
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [31:0] rnd_word();
        case ($urandom_range(0, 7))
            0: return 32'sh80000000;
            1: return 32'sh7FFFFFFF;
            2: return 0;
            3: return $signed($urandom_range(0, 255)) - 128;
            4: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            default: return $urandom;
        endcase
    endfunction

    // rotation-like basis: a random permutation with random signs and jitter,
    // scaled per row so that all four quaternion branches get exercised
    task automatic rnd_basis(output logic signed [31:0] m [0:8]);
        int p [3];
        int kind;
        int k;
        kind = $urandom_range(0, 9);
        p = '{0, 1, 2};
        p.shuffle();
        for (int i = 0; i < 3; i++)
        begin
            k = kind < 2 ? 1 : $urandom_range(1, 400);
            for (int j = 0; j < 3; j++)
            begin
                if (kind >= 8)
                    m[i*3+j] = rnd_word();
                else if (j == p[i])
                    m[i*3+j] = ($urandom_range(0, 1) ? 1 : -1) *
                               (32'sd65536 * k / 16 + $signed($urandom_range(0, 4000)) - 2000);
                else
                    m[i*3+j] = $signed($urandom_range(0, 60000)) - 30000;
            end
            if (kind == 7 && $urandom_range(0, 2) == 0)
                for (int j = 0; j < 3; j++)
                    m[i*3+j] = 0;
        end
    endtask

    initial
    begin
        logic signed [31:0] m [0:8];
        logic signed [31:0] z9 [0:8];
        int guard;
        sb = new();
        n_beats = 0;
        gaps_on = 0;
        rst_n = 0;
        start = 0;
        for (int i = 0; i < 9; i++)
        begin
            elem[i] = 0;
            z9[i] = 0;
        end
        tx = 0;
        ty = 0;
        tz = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // identity, zero matrix, extremes
        m = '{32'sd65536, 0, 0, 0, 32'sd65536, 0, 0, 0, 32'sd65536};
        send(m, 0, 0, 0);
        send(z9, 32'sh7FFFFFFF, 32'sh80000000, -1);
        for (int i = 0; i < 9; i++)
            m[i] = 32'sh80000000;
        send(m, 32'sh80000000, 32'sh7FFFFFFF, 1);
        for (int i = 0; i < 9; i++)
            m[i] = 32'sh7FFFFFFF;
        send(m, -1, 0, 32'sh7FFFFFFF);
        // each branch: x, y and z dominated diagonals (half turns)
        m = '{32'sd65536, 0, 0, 0, -32'sd65536, 0, 0, 0, -32'sd65536};
        send(m, 1, 2, 3);
        m = '{-32'sd65536, 0, 0, 0, 32'sd65536, 0, 0, 0, -32'sd65536};
        send(m, 1, 2, 3);
        m = '{-32'sd65536, 0, 0, 0, -32'sd65536, 0, 0, 0, 32'sd65536};
        send(m, 1, 2, 3);
        // ties on the diagonal
        m = '{-32'sd65536, 0, 0, 0, -32'sd65536, 0, 0, 0, -32'sd65536};
        send(m, 0, 0, 0);
        m = '{0, 32'sd65536, 0, 32'sd65536, 0, 0, 0, 0, 32'sd65536};
        send(m, 0, 0, 0);
        // one zero row, and a rank-one basis
        m = '{32'sd65536, 0, 0, 0, 0, 0, 0, 0, 32'sd65536};
        send(m, 5, 6, 7);
        m = '{32'sd65536, 0, 0, 32'sd65536, 0, 0, 32'sd65536, 0, 0};
        send(m, 5, 6, 7);
        // huge scale row with small others
        m = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 1, 0, 0, 0, 1};
        send(m, 0, 0, 0);
        m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send(m, 0, 0, 0);
        // quarter turn about z, scaled
        m = '{0, 32'sd131072, 0, -32'sd131072, 0, 0, 0, 0, 32'sd196608};
        send(m, 32'sh12345678, 0, 0);

        wait_drained();
        gaps_on = 1;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
                wait_drained();
            if (n == N_RANDOM - 150)
                gaps_on = 0;
            rnd_basis(m);
            send(m, $urandom, $urandom, rnd_word());
        end
        start <= 0;
        @(negedge clk);
        guard = 0;
        while (sb.pending.size() != 0 && guard < 4 * LATENCY)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LATENCY + 20) @(negedge clk);

        $display("ran %0d transforms, %0d results checked, %0d mismatches",
                 n_beats, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

endmodule
